// ===== src/assert_macros.svh =====
// Assertion helpers used by the target select core.
// Each macro checks one implication on the rising edge of clk, held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== src/edfpts_pkg.sv =====
package edfpts_pkg;

  // Operation codes carried in s_tuser
  localparam logic [1:0] FN_RUNNING = 2'd0;
  localparam logic [1:0] FN_IDLE    = 2'd1;
  localparam logic [1:0] FN_QUERY   = 2'd2;

  // Configuration register indexes
  localparam logic REG_CPU_COUNT     = 1'b0;
  localparam logic REG_ISOLATED_MASK = 1'b1;

  // Reset values of the configuration registers
  localparam logic [4:0]  CPU_COUNT_RESET     = 5'd12;
  localparam logic [15:0] ISOLATED_MASK_RESET = 16'h0820;

  // Width of the field and of the mask
  localparam int FIELD_CPU_W = 4;
  localparam int MASK_W      = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // A CPU is isolated only if it has a mask bit and that bit is set
  function automatic logic is_iso(input logic [MASK_W-1:0] mask, input logic [6:0] c);
    return (c < 7'(MASK_W)) && mask[c[3:0]];
  endfunction

endpackage

// ===== src/edfpts_ram.sv =====
module edfpts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/edf_preemption_target_select_core.sv =====
// EDF preemption target select: keeps per CPU the deadline of the running task in a
// synchronous RAM and an idle bit in flip-flops. A running update, an idle update or an
// unused selector presents its all-zero result through the DONE state and the output
// register. A query steps through CPUs 0 to n-1, n = min(cpu_count, NUM_CPUS), reading
// one RAM entry per cycle. It ends early on the first idle isolated CPU. A stalled
// result stream holds the result in the DONE state. One item is in work at a time; the
// next transaction can be accepted in the same cycle as the result appears, while that
// result still waits in the output register. Deadline entries never written are never
// taken as candidates.
`include "assert_macros.svh"

module edf_preemption_target_select_core import edfpts_pkg::*; #(
  parameter int NUM_CPUS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // [3:0] cpu_index, [67:4] task_deadline, [68] idle_flag
  input  logic [1:0]  s_tuser,  // [1:0] func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [0] target_valid, [4:1] target_cpu, [5] target_was_idle
);

  localparam int CpuW = $clog2(NUM_CPUS);
  localparam int CntW = $clog2(NUM_CPUS + 1);

  // Input fields
  logic [1:0]             in_func;
  logic [FIELD_CPU_W-1:0] in_cpu;
  logic [63:0]            in_dl;
  logic                   in_idle;

  assign in_func = s_tuser;
  assign in_cpu  = s_tdata[3:0];
  assign in_dl   = s_tdata[67:4];
  assign in_idle = s_tdata[68];

  // Configuration registers
  logic [4:0]        cpu_count;
  logic [MASK_W-1:0] isolated_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count     <= CPU_COUNT_RESET;
      isolated_mask <= ISOLATED_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CPU_COUNT:     cpu_count     <= cfg_data[4:0];
        REG_ISOLATED_MASK: isolated_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and scan registers
  state_t           state, state_next;
  logic [NUM_CPUS-1:0] idle_bits;
  logic [NUM_CPUS-1:0] dl_valid;
  logic [CntW-1:0]  scan_cnt;
  logic [CntW-1:0]  limit;
  logic [63:0]      q_dl;
  logic             p_valid;
  logic             p_cand;
  logic [CpuW-1:0]  p_idx;
  logic [63:0]      best;
  logic [CpuW-1:0]  best_cpu;
  logic             found;
  logic             res_valid;
  logic [3:0]       res_cpu;
  logic             res_idle;
  logic             out_valid;
  logic [3:0]       out_cpu;
  logic             out_hit;
  logic             out_was_idle;

  // Handshake and decode
  logic            s_accept;
  logic            upd_ok;
  logic [CpuW-1:0] upd_idx;
  logic            slot_free;
  logic            issue;
  logic [CpuW-1:0] scan_idx;
  logic            scan_iso;
  logic            scan_idle_hit;
  logic            scan_end;
  logic            mem_we;
  logic [63:0]     rd_data;

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign upd_idx   = CpuW'(in_cpu);
  assign upd_ok    = (int'(in_cpu) < NUM_CPUS) && is_iso(isolated_mask, 7'(in_cpu));
  assign slot_free = !out_valid || m_tready;
  assign mem_we    = s_accept && (in_func == FN_RUNNING) && upd_ok;

  assign limit = (int'(cpu_count) > NUM_CPUS) ? CntW'(NUM_CPUS) : CntW'(cpu_count);

  // Scan issue stage: idle bits sit in flops, deadlines come from RAM next cycle
  assign scan_end      = (scan_cnt >= limit);
  assign issue         = (state == ST_SCAN) && !scan_end;
  assign scan_idx      = scan_cnt[CpuW-1:0];
  assign scan_iso      = is_iso(isolated_mask, 7'(scan_cnt));
  assign scan_idle_hit = issue && scan_iso && idle_bits[scan_idx];

  edfpts_ram #(
    .WIDTH(64),
    .DEPTH(NUM_CPUS)
  ) u_dl_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(upd_idx),
    .wdata(in_dl),
    .re   (issue),
    .raddr(scan_idx),
    .rdata(rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = (in_func == FN_QUERY) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_idle_hit || (scan_end && !p_valid)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Idle bits and deadline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_bits <= '1;
      dl_valid  <= '0;
    end else begin
      if (s_accept && (in_func == FN_IDLE) && upd_ok) begin
        idle_bits[upd_idx] <= in_idle;
      end
      if (mem_we) begin
        dl_valid[upd_idx] <= 1'b1;
      end
    end
  end

  // Scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue && !scan_idle_hit;
    end
  end

  // Scan datapath and result capture
  always_ff @(posedge clk) begin
    if (s_accept) begin
      q_dl      <= in_dl;
      scan_cnt  <= '0;
      best      <= '0;
      best_cpu  <= '0;
      found     <= 1'b0;
      res_valid <= 1'b0;
      res_cpu   <= '0;
      res_idle  <= 1'b0;
    end else if (state == ST_SCAN) begin
      // Advance the issue pointer and stage this CPU
      if (issue) begin
        scan_cnt <= scan_cnt + CntW'(1);
        p_idx    <= scan_idx;
        p_cand   <= scan_iso && !idle_bits[scan_idx] && dl_valid[scan_idx];
      end
      // Keep the strictly greatest deadline, lowest index on ties
      if (p_valid && p_cand && (best < rd_data)) begin
        best     <= rd_data;
        best_cpu <= p_idx;
        found    <= 1'b1;
      end
      if (scan_idle_hit) begin
        res_valid <= 1'b1;
        res_cpu   <= 4'(scan_cnt);
        res_idle  <= 1'b1;
      end else if (scan_end && !p_valid) begin
        res_valid <= found && (q_dl < best);
        res_cpu   <= (found && (q_dl < best)) ? 4'(best_cpu) : 4'd0;
        res_idle  <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && slot_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && slot_free) begin
      out_hit      <= res_valid;
      out_cpu      <= res_cpu;
      out_was_idle <= res_idle;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_was_idle, out_cpu, out_hit};

  // Checks
  `ASSERT_NEXT(a_query_scans, s_accept && (in_func == FN_QUERY), state == ST_SCAN)
  `ASSERT_NEXT(a_update_done, s_accept && (in_func != FN_QUERY), state == ST_DONE)
  `ASSERT_IMPL(a_ram_write_idle, mem_we, state == ST_IDLE)
  `ASSERT_IMPL(a_scan_bound, state == ST_SCAN, scan_cnt <= limit)
  `ASSERT_IMPL(a_pipe_in_scan, p_valid, state == ST_SCAN)

endmodule
